>>> hdl/page_bitmap_allocator_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the page bitmap allocator.
// Both macros expect clk and rst_n in the enclosing module.
// ---------------------------------------------------------------------------
`ifndef PAGE_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define PBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pba_pkg.sv
// ---------------------------------------------------------------------------
// pba_pkg
// Shared constants, codes and control types of the page bitmap allocator.
// ---------------------------------------------------------------------------
package pba_pkg;

    localparam int DEF_MAX_PAGES  = 65536;
    localparam int DEF_WORD_BITS  = 32;
    localparam int DEF_PAGE_SHIFT = 12;

    localparam int ADDR_W   = 32;
    localparam int CFG_W    = 17;
    localparam int KIND_W   = 2;
    localparam int RTYPE_W  = 8;
    localparam int STATUS_W = 2;

    localparam int PAGE_COUNT_RESET = 65536;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MFREE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_MUSED = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NOFREE = 2'd1;
    localparam logic [STATUS_W-1:0] STS_RANGE  = 2'd2;

    // only available memory counts for mark-free
    localparam logic [RTYPE_W-1:0] REGION_AVAIL = 8'd1;

    // page number width: holds a rounded-up range end and the page limit
    function automatic int pg_width(input int max_pages, input int page_shift);
        int a;
        int b;
        a = 34 - page_shift;
        b = $clog2(max_pages) + 1;
        return (a > b) ? a : b;
    endfunction

    typedef struct packed {
        logic fill;   // write all-ones word during clearing pass
        logic load;   // capture input word
        logic prep;   // clip range, issue first read
        logic step;   // evaluate one bitmap word
        logic emit;   // move result to output register
    } pba_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic scan_done;
        logic out_free;
    } pba_stat_t;

endpackage

>>> hdl/page_bitmap_allocator_top.sv
// ---------------------------------------------------------------------------
// page_bitmap_allocator_top
// Page frame allocator with one used bit per page, bitmap held in one RAM.
// ---------------------------------------------------------------------------
// Usage
//   s_* : request words. tuser = kind (0 alloc, 1 free, 2 mark region free,
//         3 mark range used) and region type; tdata = byte address and byte
//         length; tlast marks the last memory map entry and is ignored.
//   m_* : one result word per request: tdata = allocated page byte address
//         (zero unless an allocation succeeded), tuser = status.
//   cfg_* : writes the page count; the page limit is min(count, MAX_PAGES).
// Reset
//   Every page reads as used. After reset the RAM is swept to all ones, one
//   word a cycle, and s_tready stays low until the sweep has written the
//   last word. Config writes are taken during the sweep.
// Scan
//   Each accepted item is prepared and then scanned from bitmap word 0 on,
//   one word per cycle through the read/modify/write path: up to the lowest
//   free page for an allocate, up to the clipped range end for the others.
//   The next item is taken only after the last one's result is emitted.
// Back-pressure
//   Results sit in an output register; the next item is accepted while one
//   waits, and a finished item holds until m_tready frees the register.
// ---------------------------------------------------------------------------
module page_bitmap_allocator_top #(
    parameter int MAX_PAGES  = pba_pkg::DEF_MAX_PAGES,
    parameter int WORD_BITS  = pba_pkg::DEF_WORD_BITS,
    parameter int PAGE_SHIFT = pba_pkg::DEF_PAGE_SHIFT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pba_pkg::CFG_W-1:0]  cfg_data,    // page count
    // request stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [63:0]                s_tdata,     // [31:0] byte_address, [63:32] byte_length
    input  logic [9:0]                 s_tuser,     // [1:0] kind, [9:2] region_type
    input  logic                       s_tlast,     // last_region, no effect
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,     // [31:0] page_address
    output logic [1:0]                 m_tuser      // [1:0] status
);
    import pba_pkg::*;

    localparam int CW = pg_width(MAX_PAGES, PAGE_SHIFT);
    // page limit after reset
    localparam int LIM_RST = (PAGE_COUNT_RESET > MAX_PAGES) ? MAX_PAGES : PAGE_COUNT_RESET;

    pba_cmd_t          cmd;
    pba_stat_t         stat;
    logic [CW-1:0]     lim_reg;
    logic [CW-1:0]     lim_next;

    // config: clamp once at write time so the datapath sees the limit only
    assign cfg_ready = 1'b1;
    always_comb
    begin
        lim_next = lim_reg;
        if (cfg_valid)
        begin
            if (32'(cfg_data) > 32'(MAX_PAGES))
            begin
                lim_next = CW'(MAX_PAGES);
            end
            else
            begin
                lim_next = CW'(cfg_data);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= CW'(LIM_RST);
        end
        else
        begin
            lim_reg <= lim_next;
        end
    end

    pba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pba_dp #(
        .MAX_PAGES  (MAX_PAGES),
        .WORD_BITS  (WORD_BITS),
        .PAGE_SHIFT (PAGE_SHIFT),
        .CW         (CW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .lim          (lim_reg),
        .kind         (s_tuser[1:0]),
        .byte_address (s_tdata[31:0]),
        .byte_length  (s_tdata[63:32]),
        .region_type  (s_tuser[9:2]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .page_address (m_tdata),
        .status       (m_tuser)
    );

endmodule

>>> hdl/pba_ctrl.sv
// ---------------------------------------------------------------------------
// pba_ctrl
// Sequencer: clearing pass, item capture, word scan, result hand-off.
// ---------------------------------------------------------------------------
module pba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pba_pkg::pba_stat_t  stat,
    output pba_pkg::pba_cmd_t   cmd
);
    import pba_pkg::*;

    typedef enum logic [4:0] {
        ST_FILL = 5'b00001,
        ST_IDLE = 5'b00010,
        ST_PREP = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_FILL:
            begin
                cmd.fill = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`include "page_bitmap_allocator_top_assert.svh"

    `PBA_ASSERT_NEXT(a_accept_to_prep, accept, state_reg == ST_PREP, "accepted word not prepared")
    `PBA_ASSERT_NEXT(a_scan_to_done, (state_reg == ST_SCAN) && stat.scan_done, state_reg == ST_DONE, "scan did not finish")

endmodule

>>> hdl/pba_dp.sv
// ---------------------------------------------------------------------------
// pba_dp
// Bitmap memory, one-word-per-cycle read/modify/write scan, result register.
// ---------------------------------------------------------------------------
module pba_dp #(
    parameter int MAX_PAGES  = pba_pkg::DEF_MAX_PAGES,
    parameter int WORD_BITS  = pba_pkg::DEF_WORD_BITS,
    parameter int PAGE_SHIFT = pba_pkg::DEF_PAGE_SHIFT,
    parameter int CW         = pba_pkg::pg_width(MAX_PAGES, PAGE_SHIFT)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pba_pkg::pba_cmd_t              cmd,
    output pba_pkg::pba_stat_t             stat,
    input  logic [CW-1:0]                  lim,
    input  logic [pba_pkg::KIND_W-1:0]     kind,
    input  logic [pba_pkg::ADDR_W-1:0]     byte_address,
    input  logic [pba_pkg::ADDR_W-1:0]     byte_length,
    input  logic [pba_pkg::RTYPE_W-1:0]    region_type,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pba_pkg::ADDR_W-1:0]     page_address,
    output logic [pba_pkg::STATUS_W-1:0]   status
);
    import pba_pkg::*;

    localparam int WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BI         = $clog2(WORD_BITS);
    localparam int BW1        = $clog2(WORD_BITS + 1);
    localparam int SUM_W      = ADDR_W + 2;
    localparam logic [SUM_W-1:0] PAGE_ROUND = SUM_W'((1 << PAGE_SHIFT) - 1);

    // bitmap
    logic [WORD_BITS-1:0] mem [WORD_COUNT];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // item
    logic [KIND_W-1:0]    kind_reg;
    logic [CW-1:0]        start_reg;
    logic [CW-1:0]        end_raw_reg;
    logic [CW-1:0]        first_reg;
    logic [CW-1:0]        end_clip_reg;

    // scan
    logic [AW-1:0]        fill_idx_reg;
    logic [AW-1:0]        ev_idx_reg;
    logic [AW-1:0]        nxt_idx_reg;
    logic [CW-1:0]        ev_base_reg;

    // result
    logic [ADDR_W-1:0]    res_addr_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic                 out_valid_reg;
    logic [ADDR_W-1:0]    out_addr_reg;
    logic [STATUS_W-1:0]  out_status_reg;

    logic [SUM_W-1:0]     sum;
    logic [CW-1:0]        in_start;
    logic [CW-1:0]        in_end;
    logic [CW-1:0]        d_lo;
    logic [CW-1:0]        d_hi;
    logic [BW1-1:0]       lo_v;
    logic [BW1-1:0]       hi_v;
    logic [WORD_BITS-1:0] lane_mask;
    logic [WORD_BITS-1:0] free_v;
    logic [WORD_BITS-1:0] pick;
    logic [BI-1:0]        pick_idx;
    logic                 found;
    logic [CW-1:0]        page_num;
    logic [CW+PAGE_SHIFT-1:0] page_bytes;
    logic [WORD_BITS-1:0] upd_word;
    logic [CW:0]          base_top;
    logic                 scan_done;
    logic                 is_alloc;

    // -- capture: page span of the incoming word
    always_comb
    begin
        sum      = {2'b00, byte_address} + {2'b00, byte_length}
                   + ((kind == KIND_MUSED) ? PAGE_ROUND : '0);
        in_start = CW'(byte_address >> PAGE_SHIFT);
        case (kind)
            KIND_FREE:  in_end = in_start + CW'(1);
            KIND_MFREE: in_end = (region_type == REGION_AVAIL) ? CW'(sum >> PAGE_SHIFT) : '0;
            KIND_MUSED: in_end = CW'(sum >> PAGE_SHIFT);
            default:    in_end = '0;
        endcase
    end

    // -- lane mask: pages of this word inside [first, end)
    always_comb
    begin
        if (first_reg > ev_base_reg)
        begin
            d_lo = first_reg - ev_base_reg;
            lo_v = (d_lo >= CW'(WORD_BITS)) ? BW1'(WORD_BITS) : BW1'(d_lo);
        end
        else
        begin
            d_lo = '0;
            lo_v = '0;
        end
        if (end_clip_reg > ev_base_reg)
        begin
            d_hi = end_clip_reg - ev_base_reg;
            hi_v = (d_hi >= CW'(WORD_BITS)) ? BW1'(WORD_BITS) : BW1'(d_hi);
        end
        else
        begin
            d_hi = '0;
            hi_v = '0;
        end
        for (int i = 0; i < WORD_BITS; i++)
        begin
            lane_mask[i] = (BW1'(i) >= lo_v) && (BW1'(i) < hi_v);
        end
    end

    // -- lowest free page in the word
    always_comb
    begin
        is_alloc = (kind_reg == KIND_ALLOC);
        free_v   = ~rd_data_reg & lane_mask;
        pick     = free_v & (~free_v + WORD_BITS'(1));
        found    = is_alloc && (|free_v);
        pick_idx = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (pick[i])
            begin
                pick_idx = pick_idx | BI'(i);
            end
        end
        page_num   = ev_base_reg + CW'(pick_idx);
        page_bytes = {page_num, {PAGE_SHIFT{1'b0}}};
        base_top   = {1'b0, ev_base_reg} + (CW+1)'(WORD_BITS);
        scan_done  = found || (base_top >= {1'b0, end_clip_reg});
    end

    always_comb
    begin
        case (kind_reg)
            KIND_ALLOC: upd_word = rd_data_reg | pick;
            KIND_FREE:  upd_word = rd_data_reg & ~lane_mask;
            KIND_MFREE: upd_word = rd_data_reg & ~lane_mask;
            KIND_MUSED: upd_word = rd_data_reg | lane_mask;
            default:    upd_word = rd_data_reg;
        endcase
    end

    // -- memory ports
    assign rd_en   = cmd.prep || (cmd.step && !scan_done);
    assign rd_addr = cmd.prep ? '0 : nxt_idx_reg;
    assign wr_en   = cmd.fill || cmd.step;
    assign wr_addr = cmd.fill ? fill_idx_reg : ev_idx_reg;
    assign wr_data = cmd.fill ? '1 : upd_word;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // -- item and scan payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= kind;
            start_reg   <= in_start;
            end_raw_reg <= in_end;
        end
        if (cmd.prep)
        begin
            first_reg    <= is_alloc ? '0 : start_reg;
            end_clip_reg <= is_alloc ? lim : ((end_raw_reg > lim) ? lim : end_raw_reg);
            ev_base_reg  <= '0;
            ev_idx_reg   <= '0;
            nxt_idx_reg  <= AW'(1);
            res_addr_reg <= '0;
            res_status_reg <= ((kind_reg == KIND_FREE) && (start_reg >= lim)) ? STS_RANGE
                                                                               : STS_OK;
        end
        if (cmd.step)
        begin
            ev_base_reg <= ev_base_reg + CW'(WORD_BITS);
            ev_idx_reg  <= nxt_idx_reg;
            nxt_idx_reg <= nxt_idx_reg + AW'(1);
            if (found)
            begin
                res_addr_reg <= page_bytes[ADDR_W-1:0];
            end
            else if (is_alloc && scan_done)
            begin
                res_status_reg <= STS_NOFREE;
            end
        end
        if (cmd.emit)
        begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // -- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.fill)
            begin
                fill_idx_reg <= fill_idx_reg + AW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.fill_last = (fill_idx_reg == AW'(WORD_COUNT - 1));
    assign stat.scan_done = scan_done;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign page_address = out_addr_reg;
    assign status       = out_status_reg;

`include "page_bitmap_allocator_top_assert.svh"

    `PBA_ASSERT_NOW(a_no_rw_clash, rd_en && wr_en, rd_addr != wr_addr, "read and write hit one word")
    `PBA_ASSERT_NOW(a_alloc_in_limit, cmd.step && found, page_num < end_clip_reg, "allocated page beyond limit")
    `PBA_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid_reg, "result not presented")

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for page_bitmap_allocator_top: a shadow page bitmap
// predicts every result word, and the stream is checked in order under random
// idling, a long result hold-off and several page-count settings.
// ---------------------------------------------------------------------------
module tb;
    import pba_pkg::*;

    localparam int MAX_PAGES  = DEF_MAX_PAGES;
    localparam int WORD_BITS  = DEF_WORD_BITS;
    localparam int PAGE_SHIFT = DEF_PAGE_SHIFT;
    localparam int MAP_WORDS  = MAX_PAGES / WORD_BITS;
    localparam longint PAGE_BYTES = longint'(1) << PAGE_SHIFT;

    // one request word as the bench sees it
    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  len;
        logic [RTYPE_W-1:0] rtype;
        logic               last;
    } request_t;

    // one result word
    typedef struct {
        logic [ADDR_W-1:0]   page_addr;
        logic [STATUS_W-1:0] status;
    } grant_t;

    // -----------------------------------------------------------------------
    // Shadow bitmap plus in-order store of predicted result words.
    // note_request runs at input acceptance, check_result at output acceptance.
    // -----------------------------------------------------------------------
    class page_ledger;
        bit [WORD_BITS-1:0] used_map [MAP_WORDS];
        bit [CFG_W-1:0]     page_count;
        grant_t             expected_grants [$];
        int                 errors;
        int                 requests;
        int                 results;

        function new();
            foreach (used_map[i])
                used_map[i] = '1;
            page_count = CFG_W'(PAGE_COUNT_RESET);
        endfunction

        function void set_page_count(bit [CFG_W-1:0] v);
            page_count = v;
        endfunction

        function longint page_limit();
            return (page_count > MAX_PAGES) ? MAX_PAGES : page_count;
        endfunction

        function void set_page(int p, bit v);
            used_map[p / WORD_BITS][p % WORD_BITS] = v;
        endfunction

        // pages [first, stop) with stop clipped to the page limit
        function void mark_span(longint first, longint stop, bit v);
            longint lim;
            lim = page_limit();
            if (stop > lim)
                stop = lim;
            for (longint p = first; p < stop; p++)
                set_page(int'(p), v);
        endfunction

        function void note_request(request_t r);
            grant_t g;
            longint lim;
            int     p;
            bit     found;
            g.page_addr = '0;
            g.status    = STS_OK;
            lim         = page_limit();
            requests++;
            case (r.kind)
                KIND_ALLOC:
                begin
                    found = 1'b0;
                    p     = 0;
                    while (!found && p < lim)
                    begin
                        if (used_map[p / WORD_BITS] == '1)
                            p = (p / WORD_BITS + 1) * WORD_BITS;
                        else if (!used_map[p / WORD_BITS][p % WORD_BITS])
                            found = 1'b1;
                        else
                            p++;
                    end
                    if (found)
                    begin
                        set_page(p, 1'b1);
                        g.page_addr = ADDR_W'(p) << PAGE_SHIFT;
                    end
                    else
                        g.status = STS_NOFREE;
                end
                KIND_FREE:
                begin
                    if (longint'(r.addr >> PAGE_SHIFT) >= lim)
                        g.status = STS_RANGE;
                    else
                        set_page(int'(r.addr >> PAGE_SHIFT), 1'b0);
                end
                KIND_MFREE:
                begin
                    // end rounded down; only available memory is released
                    if (r.rtype == REGION_AVAIL)
                        mark_span(longint'(r.addr) >> PAGE_SHIFT,
                                  (longint'(r.addr) + longint'(r.len)) >> PAGE_SHIFT, 1'b0);
                end
                default:
                begin
                    // end rounded up, sum taken without wrap
                    mark_span(longint'(r.addr) >> PAGE_SHIFT,
                              (longint'(r.addr) + longint'(r.len) + PAGE_BYTES - 1)
                                  >> PAGE_SHIFT, 1'b1);
                end
            endcase
            expected_grants.push_back(g);
        endfunction

        function void check_result(logic [ADDR_W-1:0] page_addr,
                                   logic [STATUS_W-1:0] status);
            grant_t g;
            results++;
            if (expected_grants.size() == 0)
            begin
                errors++;
                $display("%0t: result word with nothing pending, page_address %h status %0d",
                         $time, page_addr, status);
                return;
            end
            g = expected_grants.pop_front();
            if (page_addr !== g.page_addr)
            begin
                errors++;
                $display("%0t: page_address expected %h actual %h",
                         $time, g.page_addr, page_addr);
            end
            if (status !== g.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, g.status, status);
            end
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // DUT signals
    // -----------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [63:0]        s_tdata;    // [31:0] byte_address, [63:32] byte_length
    logic [9:0]         s_tuser;    // [1:0] kind, [9:2] region_type
    logic               s_tlast;    // last_region
    logic               m_tvalid;
    logic               m_tready;
    logic [31:0]        m_tdata;    // [31:0] page_address
    logic [1:0]         m_tuser;    // [1:0] status

    page_ledger ledger = new();

    // idling control shared by both sides
    bit calm;           // no gaps, no stalls
    int hold_asked;     // bumped to ask the result side for one long hold-off

    page_bitmap_allocator_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // hard stop; sized for every request walking the whole bitmap several
    // times over, plus the post-reset sweep and the hold-off
    initial
    begin
        #(64'd60_000_000);
        $display("FAIL page_bitmap_allocator_top");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Result side: random stalls, one long counted hold-off on request
    // -----------------------------------------------------------------------
    initial
    begin
        int hold_left;
        int hold_taken;
        hold_left  = 0;
        hold_taken = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_taken)
            begin
                hold_taken = hold_asked;
                hold_left  = 250;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (calm)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 27);
        end
    end

    // result monitor: m_tready sampled here is the value the DUT saw
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            ledger.check_result(m_tdata, m_tuser);
    end

    // -----------------------------------------------------------------------
    // Request side
    // -----------------------------------------------------------------------

    // offer one word, with a random gap first; valid stays up after the
    // handshake so back-to-back words never see a low/high pair in one step
    task automatic send_item(request_t r);
        if (!calm)
        begin
            while ($urandom_range(99) < 27)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.len, r.addr};
        s_tuser  <= {r.rtype, r.kind};
        s_tlast  <= r.last;
        do
            @(posedge clk);
        while (!s_tready);
        ledger.note_request(r);
    endtask

    task automatic send_fields(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                               logic [ADDR_W-1:0] len, logic [RTYPE_W-1:0] rtype);
        request_t r;
        r.kind  = kind;
        r.addr  = addr;
        r.len   = len;
        r.rtype = rtype;
        r.last  = ledger.requests[0];
        send_item(r);
    endtask

    // block is idle once every predicted word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_page_count(bit [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        ledger.set_page_count(v);
    endtask

    // mostly addresses inside a window of span pages, some anywhere;
    // mostly short lengths, some window-sized, some anything
    function automatic request_t random_request(int span);
        request_t r;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 35)
            r.kind = KIND_ALLOC;
        else if (pick < 60)
            r.kind = KIND_FREE;
        else if (pick < 80)
            r.kind = KIND_MFREE;
        else
            r.kind = KIND_MUSED;
        if ($urandom_range(99) < 80)
            r.addr = ($urandom_range(span) << PAGE_SHIFT)
                     | $urandom_range(int'(PAGE_BYTES) - 1);
        else
            r.addr = $urandom();
        pick = $urandom_range(99);
        if (pick < 70)
            r.len = $urandom_range(6 * int'(PAGE_BYTES));
        else if (pick < 85)
            r.len = $urandom_range(span * int'(PAGE_BYTES));
        else
            r.len = $urandom();
        r.rtype = ($urandom_range(99) < 75) ? REGION_AVAIL : RTYPE_W'($urandom_range(255));
        r.last  = 1'($urandom_range(1));
        return r;
    endfunction

    task automatic random_phase(bit [CFG_W-1:0] pages, int span, int count,
                                bit quiet, bit hold);
        drain_results();
        write_page_count(pages);
        calm = quiet;
        if (hold)
            hold_asked++;
        repeat (count)
            send_item(random_request(span));
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        calm      = 1'b0;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        s_tlast   <= 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset page count (every page used after reset).
        // First words wait out the clearing sweep on s_tready.
        send_fields(KIND_ALLOC, 32'h0000_0000, 32'h0, REGION_AVAIL);      // none free
        send_fields(KIND_FREE,  32'h0000_0FFF, 32'h0, 8'h00);             // page 0
        send_fields(KIND_ALLOC, 32'h0000_0000, 32'h0, REGION_AVAIL);      // gets page 0
        send_fields(KIND_FREE,  32'h1000_0000, 32'h0, REGION_AVAIL);      // just past limit
        send_fields(KIND_FREE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);     // far out
        send_fields(KIND_FREE,  32'h0FFF_F000, 32'h0, REGION_AVAIL);      // top page
        send_fields(KIND_ALLOC, 32'h0, 32'h0, REGION_AVAIL);              // top page back
        send_fields(KIND_MFREE, 32'h0000_2000, 32'h0000_3800, REGION_AVAIL); // end rounds down
        send_fields(KIND_MFREE, 32'h0000_0000, 32'h0001_0000, 8'h00);     // wrong type
        send_fields(KIND_MFREE, 32'h0000_0000, 32'h0001_0000, 8'hFF);     // wrong type
        send_fields(KIND_MUSED, 32'h0000_3000, 32'h0000_0001, 8'h00);     // end rounds up
        send_fields(KIND_ALLOC, 32'h0, 32'h0, REGION_AVAIL);
        send_fields(KIND_ALLOC, 32'h0, 32'h0, REGION_AVAIL);
        send_fields(KIND_ALLOC, 32'h0, 32'h0, REGION_AVAIL);              // exhausted
        send_fields(KIND_MFREE, 32'h0000_5000, 32'h0, REGION_AVAIL);      // empty range
        send_fields(KIND_MUSED, 32'h0000_5000, 32'h0, REGION_AVAIL);      // empty range
        send_fields(KIND_MFREE, 32'hFFFF_F000, 32'hFFFF_FFFF, REGION_AVAIL); // 33-bit end
        send_fields(KIND_MUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hAA);     // 33-bit end

        // Directed, small page count: clipping of whole-memory ranges
        drain_results();
        write_page_count(17'd64);
        send_fields(KIND_MFREE, 32'h0000_0000, 32'hFFFF_FFFF, REGION_AVAIL); // clipped free
        send_fields(KIND_FREE,  32'h0004_0000, 32'h0, REGION_AVAIL);      // page 64, out
        send_fields(KIND_FREE,  32'h0003_F000, 32'h0, REGION_AVAIL);      // page 63, in
        send_fields(KIND_MUSED, 32'h0000_1000, 32'hFFFF_FFFF, 8'h55);     // clipped use
        send_fields(KIND_ALLOC, 32'h0, 32'h0, REGION_AVAIL);              // page 0
        send_fields(KIND_ALLOC, 32'h0, 32'h0, REGION_AVAIL);              // none left

        // Random phases: page count, address window, words, calm, hold-off
        random_phase(17'd40, 48, 70, 1'b0, 1'b0);
        random_phase(17'h1FFFF, 300, 40, 1'b0, 1'b1);   // above max, result side held
        random_phase(17'd1, 4, 30, 1'b0, 1'b0);
        random_phase(17'd0, 4, 15, 1'b0, 1'b0);
        begin
            int pages;
            pages = $urandom_range(2000, 33);
            random_phase(CFG_W'(pages), pages + 16, 70, 1'b1, 1'b0);
        end
        random_phase(17'd65536, 600, 45, 1'b0, 1'b0);

        drain_results();
        calm = 1'b0;
        repeat (40)
            @(posedge clk);

        $display("Covered %0d requests, %0d result words checked, %0d mismatches",
                 ledger.requests, ledger.results, ledger.errors);
        $display("Page counts 0, 1, 40, 64, random, 65536 and above max; held result stream");
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("PASS page_bitmap_allocator_top");
        else
            $display("FAIL page_bitmap_allocator_top");
        $finish;
    end

endmodule
